@@ rtl/crc16_frame_checker_core_defines.svh @@
// Assertion macros for the checker file of the frame checker.
// No dependencies; included by bare file name where assertions are written.
`ifndef CRC16_FRAME_CHECKER_CORE_DEFINES_SVH
`define CRC16_FRAME_CHECKER_CORE_DEFINES_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define CRC16FC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define CRC16FC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/crc16fc_pkg.sv @@
// Package of the CRC-16 frame checker: types, frame constants and the CRC byte update.
// No dependencies; used by the interfaces and by every module of the block.
package crc16fc_pkg;

    localparam int unsigned FRAME_LEN  = 7;
    localparam int unsigned CRC_BYTES  = 5;
    localparam int unsigned COUNT_W    = 4;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  HDR_FIRST  = 8'hAA;
    localparam logic [7:0]  HDR_SECOND = 8'hCC;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_LENGTH = 2'd1,
        ST_HEADER = 2'd2,
        ST_CRC    = 2'd3
    } t_status;

    typedef struct packed {
        t_status    status;
        logic [7:0] payload_first;
        logic [7:0] payload_second;
        logic [7:0] payload_third;
    } t_result;

    // One byte of the reflected CRC, least significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

@@ rtl/crc16fc_if.sv @@
// Valid/ready channel interfaces for the frame checker's byte input and result output.
// Depends on crc16fc_pkg for the status type.
interface crc16fc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crc16fc_out_if;
    logic                 valid;
    logic                 ready;
    crc16fc_pkg::t_status status;
    logic [7:0]           payload_first;
    logic [7:0]           payload_second;
    logic [7:0]           payload_third;

    modport source (output valid, output status, output payload_first,
                    output payload_second, output payload_third, input ready);
    modport sink   (input valid, input status, input payload_first,
                    input payload_second, input payload_third, output ready);
endinterface

@@ rtl/crc16fc_frame.sv @@
// Frame state of the checker: running CRC, byte count, header flag and stored bytes.
// Depends on crc16fc_pkg; produces one result word on the final byte of a frame.
module crc16fc_frame (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output logic                 o_res_valid,
    output crc16fc_pkg::t_result o_res
);
    import crc16fc_pkg::*;

    logic [15:0]        r_crc,       n_crc;
    logic [COUNT_W-1:0] r_count,     n_count;
    logic               r_hdr_good,  n_hdr_good;
    logic [23:0]        r_payload,   n_payload;
    logic [7:0]         r_crc_high,  n_crc_high;
    logic [15:0]        rx_crc;
    t_status            status;

    always_comb begin
        n_crc      = r_crc;
        n_hdr_good = r_hdr_good;
        n_payload  = r_payload;
        n_crc_high = r_crc_high;
        n_count    = r_count;

        if (r_count < COUNT_W'(CRC_BYTES)) begin
            n_crc = crc_byte(r_crc, i_data_byte);
        end
        if (r_count == COUNT_W'(0) && i_data_byte != HDR_FIRST) begin
            n_hdr_good = 1'b0;
        end
        if (r_count == COUNT_W'(1) && i_data_byte != HDR_SECOND) begin
            n_hdr_good = 1'b0;
        end
        if (r_count == COUNT_W'(2)) begin
            n_payload[7:0] = r_payload[7:0] | i_data_byte;
        end
        if (r_count == COUNT_W'(3)) begin
            n_payload[15:8] = r_payload[15:8] | i_data_byte;
        end
        if (r_count == COUNT_W'(4)) begin
            n_payload[23:16] = r_payload[23:16] | i_data_byte;
        end
        if (r_count == COUNT_W'(5)) begin
            n_crc_high = i_data_byte;
        end
        if (r_count != COUNT_MAX) begin
            n_count = r_count + COUNT_W'(1);
        end

        // The received CRC arrives high byte first, so the final byte is the low half.
        rx_crc = {n_crc_high, i_data_byte};
        if (n_count != COUNT_W'(FRAME_LEN)) begin
            status = ST_LENGTH;
        end else if (!n_hdr_good) begin
            status = ST_HEADER;
        end else if (rx_crc != n_crc) begin
            status = ST_CRC;
        end else begin
            status = ST_OK;
        end

        o_res_valid = i_accept && i_last_byte;
        o_res.status = status;
        if (status == ST_OK) begin
            o_res.payload_first  = n_payload[7:0];
            o_res.payload_second = n_payload[15:8];
            o_res.payload_third  = n_payload[23:16];
        end else begin
            o_res.payload_first  = 8'h00;
            o_res.payload_second = 8'h00;
            o_res.payload_third  = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_crc      <= CRC_INIT;
            r_count    <= '0;
            r_hdr_good <= 1'b1;
            r_payload  <= '0;
            r_crc_high <= '0;
        end else if (i_accept) begin
            r_crc      <= n_crc;
            r_count    <= n_count;
            r_hdr_good <= n_hdr_good;
            r_payload  <= n_payload;
            r_crc_high <= n_crc_high;
        end
    end

endmodule

@@ rtl/crc16fc_out_buf.sv @@
// Result register with a skid stage, so a word can be taken in while another waits.
// Depends on crc16fc_pkg for the result word type.
module crc16fc_out_buf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  crc16fc_pkg::t_result i_data,
    output logic                 o_room,
    output logic                 o_valid,
    output crc16fc_pkg::t_result o_data,
    input  logic                 i_ready
);
    import crc16fc_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    take;

    assign take    = r_out_valid && i_ready;
    assign o_room  = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            // A push only happens while the skid stage is empty.
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_out_valid || take) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end else if (take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

endmodule

@@ rtl/crc16_frame_checker_core.sv @@
// Channel   | Dir | Word contents
// ----------+-----+--------------------------------------------------------
// i_in      | in  | data_byte[7:0], last_byte
// o_out     | out | status[1:0], payload_first, payload_second, payload_third
//
// One byte is taken per cycle while the skid slot is free; the CRC update, header
// and length checks are a single combinational pass from the frame state into the
// result register, loaded with a frame's result when its final byte is accepted.
// Reset clears the frame state to the start of a frame and empties both result slots.
// Input is held off only when the result register and its skid slot are both full.
// Top level of the CRC-16 frame checker; depends on crc16fc_pkg, crc16fc_if,
// crc16fc_frame and crc16fc_out_buf.
module crc16_frame_checker_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    crc16fc_in_if.sink    i_in,
    crc16fc_out_if.source o_out
);
    import crc16fc_pkg::*;

    logic    accept;
    logic    room;
    logic    res_valid;
    t_result res;
    logic    out_valid;
    t_result out_data;

    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    crc16fc_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    crc16fc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_room  (room),
        .o_valid (out_valid),
        .o_data  (out_data),
        .i_ready (o_out.ready)
    );

    assign o_out.valid          = out_valid;
    assign o_out.status         = out_data.status;
    assign o_out.payload_first  = out_data.payload_first;
    assign o_out.payload_second = out_data.payload_second;
    assign o_out.payload_third  = out_data.payload_third;

endmodule

@@ rtl/crc16fc_checker.sv @@
// Port-level assertions for the CRC-16 frame checker, bound to its top level.
// Depends on crc16fc_pkg and crc16_frame_checker_core_defines.svh.
`include "crc16_frame_checker_core_defines.svh"

module crc16fc_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_in_last,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input crc16fc_pkg::t_status i_status,
    input logic [7:0]           i_pay_first,
    input logic [7:0]           i_pay_second,
    input logic [7:0]           i_pay_third
);
    import crc16fc_pkg::*;

    `CRC16FC_ASSERT(a_out_held, i_out_valid && !i_out_ready |=> i_out_valid, "result word dropped while stalled")
    `CRC16FC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !i_out_valid, "result valid right after reset")
    `CRC16FC_ASSERT(a_stall_needs_result, !i_in_ready |-> i_out_valid, "input stalled with no result waiting")
    `CRC16FC_ASSERT(a_no_invented_result, !i_out_valid && !(i_in_valid && i_in_ready && i_in_last) |=> !i_out_valid, "result without a final byte")
    `CRC16FC_ASSERT(a_failed_payload_zero, i_out_valid && i_status != ST_OK |-> i_pay_first == 8'h00 && i_pay_second == 8'h00 && i_pay_third == 8'h00, "payload set on a failed frame")

endmodule

bind crc16_frame_checker_core crc16fc_checker u_crc16fc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_last    (i_in.last_byte),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_status     (o_out.status),
    .i_pay_first  (o_out.payload_first),
    .i_pay_second (o_out.payload_second),
    .i_pay_third  (o_out.payload_third)
);

@@ tb/crc16_frame_checker_core_tb_chk.sv @@
// Result checker for the CRC-16 frame checker: watches both channels, predicts
// each frame's status and payload, and counts mismatches. Depends on crc16fc_pkg
// and crc16fc_if; also holds the small package with the predictor's bitwise CRC.
`timescale 1ns / 1ps

package crc16_tb_pkg;
    import crc16fc_pkg::*;

    // Reflected CRC-16, one data bit at a time, least significant bit first.
    function automatic logic [15:0] crc16_next(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        logic        feedback;
        crc = crc_in;
        for (int i = 0; i < 8; i++) begin
            feedback = crc[0] ^ data[i];
            crc = {1'b0, crc[15:1]};
            if (feedback) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction
endpackage

module frame_result_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    crc16fc_in_if  i_in_mon,
    crc16fc_out_if i_out_mon,
    output int     o_fail_count,
    output int     o_pending,
    output int     o_checked,
    output int     o_good_frames
);
    import crc16fc_pkg::*;
    import crc16_tb_pkg::*;

    logic [15:0]        frame_crc;
    logic [COUNT_W-1:0] frame_len;
    logic               header_ok;
    logic [23:0]        payload_bytes;
    logic [7:0]         rx_crc_high;
    t_result            expected_results[$];

    task automatic start_frame();
        frame_crc     = CRC_INIT;
        frame_len     = '0;
        header_ok     = 1'b1;
        payload_bytes = '0;
        rx_crc_high   = '0;
    endtask

    // Advance the frame state by one byte; on the final byte queue its result.
    task automatic take_byte(input logic [7:0] b, input logic is_last);
        t_result     res;
        logic [15:0] rx_crc;
        if (frame_len < CRC_BYTES) begin
            frame_crc = crc16_next(frame_crc, b);
        end
        if (frame_len == 0 && b != HDR_FIRST) begin
            header_ok = 1'b0;
        end
        if (frame_len == 1 && b != HDR_SECOND) begin
            header_ok = 1'b0;
        end
        case (frame_len)
            4'd2: payload_bytes[7:0]   = b;
            4'd3: payload_bytes[15:8]  = b;
            4'd4: payload_bytes[23:16] = b;
            4'd5: rx_crc_high          = b;
            default: ;
        endcase
        if (frame_len != COUNT_MAX) begin
            frame_len = frame_len + 1'b1;
        end
        if (is_last) begin
            rx_crc = {rx_crc_high, b};
            if (frame_len != FRAME_LEN) begin
                res.status = ST_LENGTH;
            end else if (!header_ok) begin
                res.status = ST_HEADER;
            end else if (rx_crc != frame_crc) begin
                res.status = ST_CRC;
            end else begin
                res.status = ST_OK;
            end
            if (res.status == ST_OK) begin
                {res.payload_third, res.payload_second, res.payload_first} = payload_bytes;
            end else begin
                {res.payload_third, res.payload_second, res.payload_first} = '0;
            end
            expected_results.push_back(res);
            start_frame();
        end
    endtask

    task automatic compare_result();
        t_result exp_res;
        if (expected_results.size() == 0) begin
            $display("%0t: result with no frame pending: status %0d payload %h %h %h",
                     $time, i_out_mon.status, i_out_mon.payload_first,
                     i_out_mon.payload_second, i_out_mon.payload_third);
            o_fail_count++;
        end else begin
            exp_res = expected_results.pop_front();
            o_checked++;
            if (exp_res.status == ST_OK) begin
                o_good_frames++;
            end
            if (i_out_mon.status !== exp_res.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, exp_res.status, i_out_mon.status);
                o_fail_count++;
            end
            if (i_out_mon.payload_first !== exp_res.payload_first) begin
                $display("%0t: payload_first expected %h actual %h",
                         $time, exp_res.payload_first, i_out_mon.payload_first);
                o_fail_count++;
            end
            if (i_out_mon.payload_second !== exp_res.payload_second) begin
                $display("%0t: payload_second expected %h actual %h",
                         $time, exp_res.payload_second, i_out_mon.payload_second);
                o_fail_count++;
            end
            if (i_out_mon.payload_third !== exp_res.payload_third) begin
                $display("%0t: payload_third expected %h actual %h",
                         $time, exp_res.payload_third, i_out_mon.payload_third);
                o_fail_count++;
            end
        end
    endtask

    initial begin
        o_fail_count  = 0;
        o_checked     = 0;
        o_good_frames = 0;
        o_pending     = 0;
        start_frame();
    end

    // A result accepted on this edge belongs to an earlier frame, so it is
    // compared before the byte taken on the same edge is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_frame();
            expected_results.delete();
        end else begin
            if (i_out_mon.valid === 1'b1 && i_out_mon.ready === 1'b1) begin
                compare_result();
            end
            if (i_in_mon.valid === 1'b1 && i_in_mon.ready === 1'b1) begin
                take_byte(i_in_mon.data_byte, i_in_mon.last_byte);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

@@ tb/crc16_frame_checker_core_tb.sv @@
// Top of the frame checker testbench: clock, reset, frame stimulus and verdict.
// Depends on crc16fc_pkg, crc16fc_if, the block itself and the result checker.
`timescale 1ns / 1ps

module crc16_frame_checker_core_tb;
    import crc16fc_pkg::*;

    localparam int BYTE_TARGET = 1350;
    localparam int CYCLE_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   quiet = 1'b0;
    int   sent_bytes = 0;
    int   sent_frames = 0;
    int   cycles = 0;
    int   fail_count;
    int   pending;
    int   checked;
    int   good_frames;

    logic [7:0] frame_buf[$];

    crc16fc_in_if  in_ch();
    crc16fc_out_if out_ch();

    crc16_frame_checker_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    frame_result_checker result_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_good_frames (good_frames)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: stalls at random except during the quiet stretch.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= quiet || ($urandom_range(99) >= 38);
        end
    end

    // Entered and left at a falling edge; returns once the word is accepted.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while (!quiet && $urandom_range(99) < 38) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= is_last;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        sent_bytes++;
        quiet = (sent_bytes >= 500 && sent_bytes < 800);
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        foreach (frame_buf[i]) begin
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
        sent_frames++;
    endtask

    // Well-formed frame: header, three payload bytes, CRC high byte first.
    task automatic build_good(input logic [7:0] p0, input logic [7:0] p1,
                              input logic [7:0] p2);
        logic [15:0] crc;
        frame_buf = '{HDR_FIRST, HDR_SECOND, p0, p1, p2};
        crc = CRC_INIT;
        foreach (frame_buf[i]) begin
            crc = crc_byte(crc, frame_buf[i]);
        end
        frame_buf.push_back(crc[15:8]);
        frame_buf.push_back(crc[7:0]);
    endtask

    task automatic build_random();
        int kind;
        int n;
        kind = $urandom_range(99);
        build_good(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
        if (kind < 60) begin
            // keep the well-formed frame
        end else if (kind < 70) begin
            n = $urandom_range(1);
            frame_buf[n] = frame_buf[n] ^ (8'h01 << $urandom_range(7));
        end else if (kind < 80) begin
            n = $urandom_range(6, 2);
            frame_buf[n] = frame_buf[n] ^ (8'h01 << $urandom_range(7));
        end else if (kind < 90) begin
            if ($urandom_range(1) == 0) begin
                n = $urandom_range(6, 1);
                while (frame_buf.size() > n) void'(frame_buf.pop_back());
            end else begin
                // Mostly a little too long, now and then past the count's saturation.
                n = ($urandom_range(7) == 0) ? $urandom_range(17, 9) : $urandom_range(3, 1);
                repeat (n) frame_buf.push_back(8'($urandom_range(255)));
            end
        end else begin
            n = $urandom_range(10, 1);
            frame_buf.delete();
            repeat (n) frame_buf.push_back(8'($urandom_range(255)));
            if ($urandom_range(1) == 0) begin
                frame_buf[0] = HDR_FIRST;
            end
        end
    endtask

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        out_ch.ready    = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Good frame with payload extremes, then a frame with inverted payload and a bad CRC.
        build_good(8'h00, 8'hFF, 8'h5A);
        send_frame();
        build_good(8'hFF, 8'h00, 8'hA5);
        frame_buf[6] = ~frame_buf[6];
        send_frame();
        // Single-byte frame, and an eight-byte frame with a correct header.
        frame_buf = '{8'hAA};
        send_frame();
        build_good(8'h12, 8'h34, 8'h56);
        frame_buf.push_back(8'hFF);
        send_frame();

        while (sent_bytes < BYTE_TARGET) begin
            build_random();
            send_frame();
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d bytes in %0d frames (good, corrupted, short, long and noise).",
                 sent_bytes, sent_frames);
        $display("Checked %0d frame results, %0d of them good frames; %0d mismatches.",
                 checked, good_frames, fail_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
